// File: sv/cpcd_pkg.sv
package cpcd_pkg;

    typedef enum logic [2:0] {
        PH_TYPE   = 3'd0,
        PH_LEN    = 3'd1,
        PH_WIDTHS = 3'd2,
        PH_COUNTS = 3'd3,
        PH_ALPHA  = 3'd4,
        PH_DECODE = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_TYPE  = 3'd1,
        ST_SIZES = 3'd2,
        ST_CODE  = 3'd3,
        ST_EARLY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_FETCH = 3'd1,
        S_BIT   = 3'd2,
        S_LOOK  = 3'd3,
        S_EMIT  = 3'd4,
        S_EOF   = 3'd5
    } t_seq;

    localparam logic [7:0] DELTA_FLAG = 8'h80;
    localparam int         DATA_W     = 8;
    localparam int         STATUS_W   = 3;

endpackage

// File: sv/cpcd_if.sv
interface cpcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;
    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface cpcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_symbol;
    logic [2:0] status;
    modport source (output valid, output symbol, output last_symbol, output status,
                    input ready);
    modport sink   (input valid, input symbol, input last_symbol, input status,
                    output ready);
endinterface

// File: sv/cpcd_ram.sv
module cpcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/canonical_prefix_code_decoder_top.sv
// Canonical prefix-code decoder. Takes one compressed byte per input beat and
// returns decoded bytes, one output beat each, with the last byte of a file and
// any error beat marked by last_symbol. A header byte passes through an
// accepting step, a processing step and a closing step that also handles end
// of file. In the code phase each examined bit takes a code table read, then the
// compare that issues the alphabet read, and each decoded symbol adds the
// alphabet data, then the output beat. A stalled output holds the decoder. The
// registered reads of the code table and alphabet memories set these steps.
// Only one byte is in work at a time.
module canonical_prefix_code_decoder_top #(
    parameter int MAX_CODE_LENGTHS = 16,
    parameter int ALPHABET_DEPTH   = 256,
    parameter int LENGTH_BITS      = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpcd_in_if.sink     in_ch,
    cpcd_out_if.source  out_ch
);
    localparam int LW = $clog2(MAX_CODE_LENGTHS);
    localparam int AW = (ALPHABET_DEPTH > 1) ? $clog2(ALPHABET_DEPTH) : 1;
    localparam int TW = 33;

    cpcd_pkg::t_seq   r_seq, n_seq;
    cpcd_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_byte, n_byte;
    logic        r_eof, n_eof;
    logic [3:0]  r_bit, n_bit;
    logic [8:0]  r_hidx, n_hidx;
    logic [23:0] r_total, n_total;
    logic [23:0] r_rem, n_rem;
    logic        r_delta, n_delta;
    logic [4:0]  r_lcount, n_lcount;
    logic [8:0]  r_asize, n_asize;
    logic [15:0] r_acc, n_acc;
    logic [4:0]  r_taken, n_taken;
    logic [7:0]  r_prev, n_prev;
    logic        r_err, n_err;
    logic [16:0] r_last_limit, n_last_limit;
    logic        r_ov, n_ov;
    logic [7:0]  r_osym, n_osym;
    logic        r_olast, n_olast;
    logic [2:0]  r_ost, n_ost;

    logic          tab_we;
    logic [LW-1:0] tab_waddr, tab_raddr;
    logic [TW-1:0] tab_wdata, tab_rdata;
    logic          alp_we;
    logic [AW-1:0] alp_waddr, alp_raddr;
    logic [7:0]    alp_wdata, alp_rdata;

    cpcd_ram #(.WIDTH(TW), .DEPTH(MAX_CODE_LENGTHS)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_waddr), .i_wdata(tab_wdata),
        .i_raddr(tab_raddr), .o_rdata(tab_rdata)
    );
    cpcd_ram #(.WIDTH(8), .DEPTH(ALPHABET_DEPTH)) u_alp (
        .i_clk(i_clk), .i_we(alp_we), .i_waddr(alp_waddr), .i_wdata(alp_wdata),
        .i_raddr(alp_raddr), .o_rdata(alp_rdata)
    );

    logic        out_free;
    logic [15:0] acc_sh;
    logic [4:0]  taken_inc;
    logic [16:0] pre_lim, after;
    logic [9:0]  asum;
    logic [16:0] lim;
    logic [15:0] offs, idx;
    logic [7:0]  sym;
    logic [16:0] cap;

    assign out_free     = !r_ov || out_ch.ready;
    assign in_ch.ready  = (r_seq == cpcd_pkg::S_IDLE) && out_free;
    assign out_ch.valid = r_ov;
    assign out_ch.symbol      = r_osym;
    assign out_ch.last_symbol = r_olast;
    assign out_ch.status      = r_ost;

    assign acc_sh    = {r_acc[14:0], r_byte[r_bit[2:0]]};
    assign taken_inc = r_taken + 5'd1;
    assign lim       = tab_rdata[16:0];
    assign offs      = tab_rdata[32:17];
    assign idx       = r_acc + offs;
    assign sym       = r_delta ? r_prev + alp_rdata : alp_rdata;
    assign pre_lim   = (r_hidx == 9'd0) ? 17'd0 : {r_last_limit[15:0], 1'b0};
    assign after     = pre_lim + {9'd0, r_byte};
    assign asum      = {1'b0, r_asize} + {2'd0, r_byte};
    assign cap       = 17'd1 << (r_hidx[4:0] + 5'd1);

    always_comb begin
        tab_we    = 1'b0;
        tab_waddr = r_hidx[LW-1:0];
        tab_wdata = {{7'd0, r_asize} - pre_lim[15:0], after};
        tab_raddr = LW'((r_seq == cpcd_pkg::S_FETCH) ? r_taken : r_taken - 5'd1);
        alp_we    = 1'b0;
        alp_waddr = r_hidx[AW-1:0];
        alp_wdata = r_byte;
        alp_raddr = idx[AW-1:0];
        if (r_seq == cpcd_pkg::S_FETCH && r_phase == cpcd_pkg::PH_COUNTS
            && r_hidx < 9'(MAX_CODE_LENGTHS) && !(after > cap)
            && !(asum > 10'(ALPHABET_DEPTH))) begin
            tab_we = 1'b1;
        end
        if (r_seq == cpcd_pkg::S_FETCH && r_phase == cpcd_pkg::PH_ALPHA
            && r_hidx < 9'(ALPHABET_DEPTH)) begin
            alp_we = 1'b1;
        end
    end

    always_comb begin
        n_seq = r_seq; n_phase = r_phase; n_byte = r_byte; n_eof = r_eof;
        n_bit = r_bit; n_hidx = r_hidx; n_total = r_total; n_rem = r_rem;
        n_delta = r_delta; n_lcount = r_lcount; n_asize = r_asize; n_acc = r_acc;
        n_taken = r_taken; n_prev = r_prev; n_err = r_err;
        n_last_limit = r_last_limit;
        n_ov = r_ov && !out_ch.ready;
        n_osym = r_osym; n_olast = r_olast; n_ost = r_ost;
        case (r_seq)
            cpcd_pkg::S_IDLE: begin
                if (in_ch.valid && out_free) begin
                    n_byte = in_ch.data_byte;
                    n_eof  = in_ch.end_of_file;
                    n_bit  = 4'd7;
                    n_seq  = r_err ? cpcd_pkg::S_EOF : cpcd_pkg::S_FETCH;
                end
            end
            cpcd_pkg::S_FETCH: begin
                n_seq = cpcd_pkg::S_EOF;
                case (r_phase)
                    cpcd_pkg::PH_TYPE: begin
                        if (r_byte != 8'd2) begin
                            n_ov = 1'b1; n_osym = '0; n_olast = 1'b1;
                            n_ost = cpcd_pkg::ST_TYPE; n_err = 1'b1;
                        end else begin
                            n_hidx = '0; n_total = '0; n_rem = '0; n_delta = 1'b0;
                            n_lcount = '0; n_asize = '0; n_acc = '0; n_taken = '0;
                            n_prev = '0; n_phase = cpcd_pkg::PH_LEN;
                        end
                    end
                    cpcd_pkg::PH_LEN: begin
                        case (r_hidx[1:0])
                            2'd0: n_total[7:0]   = r_byte;
                            2'd1: n_total[15:8]  = r_byte;
                            default: n_total[23:16] = r_byte;
                        endcase
                        n_hidx = r_hidx + 9'd1;
                        if (r_hidx == 9'd2) begin
                            if (LENGTH_BITS < 24 && (n_total >> LENGTH_BITS) != 24'd0) begin
                                n_ov = 1'b1; n_osym = '0; n_olast = 1'b1;
                                n_ost = cpcd_pkg::ST_SIZES; n_err = 1'b1;
                                n_phase = cpcd_pkg::PH_TYPE;
                            end else begin
                                n_rem = n_total; n_hidx = '0;
                                n_phase = cpcd_pkg::PH_WIDTHS;
                            end
                        end
                    end
                    cpcd_pkg::PH_WIDTHS: begin
                        n_delta = (r_byte & cpcd_pkg::DELTA_FLAG) != 8'd0;
                        n_hidx  = '0;
                        if (r_byte[6:0] > 7'(MAX_CODE_LENGTHS)) begin
                            n_ov = 1'b1; n_osym = '0; n_olast = 1'b1;
                            n_ost = cpcd_pkg::ST_SIZES; n_err = 1'b1;
                            n_phase = cpcd_pkg::PH_TYPE;
                        end else begin
                            n_lcount = r_byte[4:0];
                            if (r_byte[6:0] == 7'd0) begin
                                n_acc = '0; n_taken = '0;
                                n_phase = (r_rem == '0) ? cpcd_pkg::PH_DONE
                                                        : cpcd_pkg::PH_DECODE;
                            end else begin
                                n_phase = cpcd_pkg::PH_COUNTS;
                            end
                        end
                    end
                    cpcd_pkg::PH_COUNTS: begin
                        if (!tab_we) begin
                            n_ov = 1'b1; n_osym = '0; n_olast = 1'b1;
                            n_ost = cpcd_pkg::ST_SIZES; n_err = 1'b1;
                            n_phase = cpcd_pkg::PH_TYPE;
                        end else begin
                            n_last_limit = after;
                            n_asize = asum[8:0];
                            n_hidx  = r_hidx + 9'd1;
                            if (n_hidx >= {4'd0, r_lcount}) begin
                                n_hidx = '0;
                                if (n_asize == '0) begin
                                    n_acc = '0; n_taken = '0;
                                    n_phase = (r_rem == '0) ? cpcd_pkg::PH_DONE
                                                            : cpcd_pkg::PH_DECODE;
                                end else begin
                                    n_phase = cpcd_pkg::PH_ALPHA;
                                end
                            end
                        end
                    end
                    cpcd_pkg::PH_ALPHA: begin
                        n_hidx = r_hidx + 9'd1;
                        if (n_hidx >= r_asize) begin
                            n_hidx = '0; n_acc = '0; n_taken = '0;
                            n_phase = (r_rem == '0) ? cpcd_pkg::PH_DONE
                                                    : cpcd_pkg::PH_DECODE;
                        end
                    end
                    cpcd_pkg::PH_DECODE: begin
                        n_acc = acc_sh; n_taken = taken_inc; n_seq = cpcd_pkg::S_BIT;
                    end
                    default: ;
                endcase
            end
            cpcd_pkg::S_BIT: begin
                if (r_taken <= r_lcount && {1'b0, r_acc} < lim) begin
                    n_seq = cpcd_pkg::S_LOOK;
                end else if (r_taken >= r_lcount) begin
                    if (out_free) begin
                        n_ov = 1'b1; n_osym = '0; n_olast = 1'b1;
                        n_ost = cpcd_pkg::ST_CODE; n_err = 1'b1;
                        n_phase = cpcd_pkg::PH_TYPE; n_seq = cpcd_pkg::S_EOF;
                    end
                end else if (r_bit == 4'd0) begin
                    n_seq = cpcd_pkg::S_EOF;
                end else begin
                    n_bit = r_bit - 4'd1;
                    n_seq = cpcd_pkg::S_FETCH;
                end
            end
            cpcd_pkg::S_LOOK: begin
                n_seq = cpcd_pkg::S_EMIT;
                n_prev = (idx < 16'(ALPHABET_DEPTH)) ? sym : (r_delta ? r_prev : 8'd0);
                n_rem = r_rem - 24'd1;
                n_acc = '0; n_taken = '0;
            end
            cpcd_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_osym = r_prev; n_ost = cpcd_pkg::ST_OK;
                    n_olast = (r_rem == '0);
                    if (r_rem == '0) begin
                        n_phase = cpcd_pkg::PH_DONE; n_seq = cpcd_pkg::S_EOF;
                    end else if (r_bit == 4'd0) begin
                        n_seq = cpcd_pkg::S_EOF;
                    end else begin
                        n_bit = r_bit - 4'd1; n_seq = cpcd_pkg::S_FETCH;
                    end
                end
            end
            cpcd_pkg::S_EOF: begin
                if (!r_eof) begin
                    n_seq = cpcd_pkg::S_IDLE;
                end else if (r_err) begin
                    n_err = 1'b0; n_phase = cpcd_pkg::PH_TYPE; n_seq = cpcd_pkg::S_IDLE;
                end else if (r_phase == cpcd_pkg::PH_DONE) begin
                    n_phase = cpcd_pkg::PH_TYPE; n_seq = cpcd_pkg::S_IDLE;
                end else if (out_free) begin
                    n_ov = 1'b1; n_osym = '0; n_olast = 1'b1;
                    n_ost = cpcd_pkg::ST_EARLY;
                    n_phase = cpcd_pkg::PH_TYPE; n_seq = cpcd_pkg::S_IDLE;
                end
            end
            default: n_seq = cpcd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= cpcd_pkg::S_IDLE; r_phase <= cpcd_pkg::PH_TYPE;
            r_hidx <= '0; r_total <= '0; r_rem <= '0; r_delta <= 1'b0;
            r_lcount <= '0; r_asize <= '0; r_acc <= '0; r_taken <= '0;
            r_prev <= '0; r_err <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_seq <= n_seq; r_phase <= n_phase;
            r_hidx <= n_hidx; r_total <= n_total; r_rem <= n_rem; r_delta <= n_delta;
            r_lcount <= n_lcount; r_asize <= n_asize; r_acc <= n_acc; r_taken <= n_taken;
            r_prev <= n_prev; r_err <= n_err; r_ov <= n_ov;
        end
        r_byte <= n_byte; r_eof <= n_eof; r_bit <= n_bit;
        r_last_limit <= n_last_limit;
        r_osym <= n_osym; r_olast <= n_olast; r_ost <= n_ost;
    end
endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [7:0]        symbol;
        logic              last_symbol;
        cpcd_pkg::t_status status;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;

    cpcd_in_if  in_ch ();
    cpcd_out_if out_ch ();

    canonical_prefix_code_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    t_decoded   pending_q[$];
    logic [7:0] file_q[$];
    bit         failed;
    bit         quiet;
    int         sent_beats;
    int         stall_left;

    // decoder mirror
    cpcd_pkg::t_phase m_phase;
    bit         m_hold;
    bit         m_delta;
    int         m_index;
    int         m_total;
    int         m_remain;
    int         m_lengths;
    int         m_asize;
    int         m_acc;
    int         m_taken;
    logic [7:0] m_prev;
    int         m_limit[16];
    int         m_offset[16];
    logic [7:0] m_alpha[256];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic void push_decoded(logic [7:0] s, logic l, cpcd_pkg::t_status st);
        t_decoded d;
        d.symbol = s;
        d.last_symbol = l;
        d.status = st;
        pending_q.push_back(d);
    endfunction

    function automatic void abort_file(cpcd_pkg::t_status st);
        push_decoded(8'h00, 1'b1, st);
        m_hold = 1'b1;
        m_phase = cpcd_pkg::PH_TYPE;
    endfunction

    function automatic void start_codes();
        m_acc = 0;
        m_taken = 0;
        m_phase = (m_remain == 0) ? cpcd_pkg::PH_DONE : cpcd_pkg::PH_DECODE;
    endfunction

    function automatic void counts_done();
        m_index = 0;
        if (m_asize == 0)
            start_codes();
        else
            m_phase = cpcd_pkg::PH_ALPHA;
    endfunction

    function automatic void decode_bits(logic [7:0] b);
        int k;
        int idx;
        logic [7:0] s;
        for (k = 7; k >= 0 && m_phase == cpcd_pkg::PH_DECODE; k--) begin
            m_acc = ((m_acc << 1) | b[k]) & 16'hFFFF;
            m_taken = (m_taken + 1) & 5'h1F;
            if (m_taken >= 1 && m_taken <= m_lengths && m_taken <= 16 &&
                m_acc < m_limit[m_taken-1]) begin
                idx = (m_acc + m_offset[m_taken-1]) & 16'hFFFF;
                s = (idx < 256) ? m_alpha[idx] : 8'h00;
                m_prev = m_delta ? m_prev + s : s;
                m_remain = (m_remain - 1) & 24'hFFFFFF;
                m_acc = 0;
                m_taken = 0;
                if (m_remain == 0) begin
                    push_decoded(m_prev, 1'b1, cpcd_pkg::ST_OK);
                    m_phase = cpcd_pkg::PH_DONE;
                end else begin
                    push_decoded(m_prev, 1'b0, cpcd_pkg::ST_OK);
                end
            end else if (m_taken >= m_lengths) begin
                abort_file(cpcd_pkg::ST_CODE);
            end
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eof);
        int pre;
        int post;
        if (m_hold) begin
            if (eof) begin
                m_hold = 1'b0;
                m_phase = cpcd_pkg::PH_TYPE;
            end
            return;
        end
        case (m_phase)
            cpcd_pkg::PH_TYPE: begin
                if (b != 8'd2) begin
                    abort_file(cpcd_pkg::ST_TYPE);
                end else begin
                    m_index = 0;
                    m_total = 0;
                    m_remain = 0;
                    m_delta = 1'b0;
                    m_lengths = 0;
                    m_asize = 0;
                    m_acc = 0;
                    m_taken = 0;
                    m_prev = 8'h00;
                    m_phase = cpcd_pkg::PH_LEN;
                end
            end
            cpcd_pkg::PH_LEN: begin
                m_total = (m_total | (int'(b) << (8 * (m_index & 3)))) & 24'hFFFFFF;
                m_index++;
                if (m_index >= 3) begin
                    m_remain = m_total;
                    m_index = 0;
                    m_phase = cpcd_pkg::PH_WIDTHS;
                end
            end
            cpcd_pkg::PH_WIDTHS: begin
                m_delta = b[7];
                m_lengths = b & 8'h7F;
                m_index = 0;
                if (m_lengths > 16)
                    abort_file(cpcd_pkg::ST_SIZES);
                else if (m_lengths == 0)
                    counts_done();
                else
                    m_phase = cpcd_pkg::PH_COUNTS;
            end
            cpcd_pkg::PH_COUNTS: begin
                pre = (m_index == 0) ? 0 : m_limit[m_index-1] * 2;
                post = pre + b;
                if (m_index >= 16 || post > (1 << (m_index + 1)) || m_asize + b > 256) begin
                    abort_file(cpcd_pkg::ST_SIZES);
                end else begin
                    m_offset[m_index] = (m_asize - pre) & 16'hFFFF;
                    m_limit[m_index] = post;
                    m_asize += b;
                    m_index++;
                    if (m_index >= m_lengths)
                        counts_done();
                end
            end
            cpcd_pkg::PH_ALPHA: begin
                if (m_index < 256)
                    m_alpha[m_index] = b;
                m_index++;
                if (m_index >= m_asize) begin
                    m_index = 0;
                    start_codes();
                end
            end
            cpcd_pkg::PH_DECODE: decode_bits(b);
            default: ;
        endcase
        if (eof) begin
            if (m_hold)
                m_hold = 1'b0;
            else if (m_phase != cpcd_pkg::PH_DONE)
                push_decoded(8'h00, 1'b1, cpcd_pkg::ST_EARLY);
            m_phase = cpcd_pkg::PH_TYPE;
        end
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic eof);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_of_file <= eof;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_byte(b, eof);
        sent_beats++;
        if (sent_beats > 100)
            quiet = 1'b1;
    endtask

    // sends the staged bytes, end of file on the last
    task automatic flush_file();
        int i;
        for (i = 0; i < file_q.size(); i++)
            send_beat(file_q[i], i == file_q.size() - 1);
        file_q.delete();
    endtask

    task automatic drain_outputs();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_q.size() != 0);
    endtask

    // chain: counts of one per length and two at the last, a full code
    task automatic send_coded_file(input int nlen, input bit delta, input int nsym,
                                   input bit chain, input int trail, input int cut);
        int cnt[16];
        int first[16];
        int offs[16];
        int pre, cap, maxb, asz, i, j, a, v;
        bit bits_q[$];
        asz = 0;
        pre = 0;
        for (i = 0; i < nlen; i++) begin
            cap = (1 << (i + 1)) - pre;
            maxb = cap;
            if (maxb > 256 - asz) maxb = 256 - asz;
            if (maxb > 255) maxb = 255;
            if (chain)
                cnt[i] = (i == nlen - 1) ? 2 : 1;
            else if (i == nlen - 1 && cap <= 8)
                cnt[i] = maxb;
            else if (i == nlen - 1 && asz == 0)
                cnt[i] = (maxb > 3) ? $urandom_range(1, 3) : maxb;
            else
                cnt[i] = $urandom_range(0, (maxb > 3) ? 3 : maxb);
            first[i] = asz;
            offs[i] = asz - pre;
            asz += cnt[i];
            pre = (pre + cnt[i]) * 2;
        end
        file_q.push_back(8'd2);
        file_q.push_back(nsym[7:0]);
        file_q.push_back(nsym[15:8]);
        file_q.push_back(nsym[23:16]);
        file_q.push_back({delta, 7'(nlen)});
        for (i = 0; i < nlen; i++)
            file_q.push_back(8'(cnt[i]));
        for (i = 0; i < asz; i++)
            file_q.push_back(8'($urandom));
        if (asz > 0) begin
            for (j = 0; j < nsym; j++) begin
                a = $urandom_range(0, asz - 1);
                for (i = 0; i < nlen; i++) begin
                    if (a >= first[i] && a < first[i] + cnt[i]) begin
                        v = a - offs[i];
                        for (int k = i; k >= 0; k--)
                            bits_q.push_back(v[k]);
                        break;
                    end
                end
            end
        end
        while (bits_q.size() % 8 != 0 || bits_q.size() == 0)
            bits_q.push_back($urandom_range(0, 1));
        for (i = 0; i < bits_q.size(); i += 8)
            file_q.push_back({bits_q[i], bits_q[i+1], bits_q[i+2], bits_q[i+3],
                              bits_q[i+4], bits_q[i+5], bits_q[i+6], bits_q[i+7]});
        for (i = 0; i < trail; i++)
            file_q.push_back(8'($urandom));
        for (i = 0; i < cut && file_q.size() > 1; i++)
            void'(file_q.pop_back());
        flush_file();
    endtask

    task automatic test_header_errors();
        file_q = '{8'hFF, 8'h02, 8'h00};
        flush_file();
        file_q = '{8'h02, 8'h01, 8'h00, 8'h00, 8'h91, 8'h55};
        flush_file();
        file_q = '{8'h02, 8'h02, 8'h00, 8'h00, 8'h01, 8'h03};
        flush_file();
        file_q = '{8'h02, 8'h01, 8'h00, 8'h00, 8'h09,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd200, 8'd100};
        flush_file();
        file_q = '{8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h81};
        flush_file();
        file_q = '{8'h02, 8'h05};
        flush_file();
    endtask

    task automatic test_degenerate_codes();
        file_q = '{8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'hAA, 8'h00};
        flush_file();
        file_q = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h7E, 8'h00, 8'hFF};
        flush_file();
    endtask

    task automatic test_decoding();
        send_coded_file(1, 1'b0, 8, 1'b0, 0, 0);
        send_coded_file(3, 1'b1, 6, 1'b0, 1, 0);
        send_coded_file(16, 1'b0, 5, 1'b1, 0, 0);
        send_coded_file(2, 1'b0, 10, 1'b0, 0, 1);
        drain_outputs();
    endtask

    task automatic test_random_files();
        int r;
        int n;
        do begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                send_coded_file(($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 5),
                                $urandom_range(0, 1), $urandom_range(1, 10), 1'b0,
                                $urandom_range(0, 2),
                                ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
            end else if (r < 9) begin
                n = $urandom_range(1, 10);
                file_q.push_back($urandom_range(0, 1) ? 8'h02 : 8'($urandom));
                repeat (n) file_q.push_back(8'($urandom));
                flush_file();
            end else begin
                drain_outputs();
            end
        end while (sent_beats < 130);
        in_ch.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_decoded d;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected beat: symbol %0h status %0d", out_ch.symbol, out_ch.status);
                failed = 1'b1;
            end else begin
                d = pending_q.pop_front();
                if (out_ch.symbol !== d.symbol) begin
                    $error("symbol: expected %0h, got %0h", d.symbol, out_ch.symbol);
                    failed = 1'b1;
                end
                if (out_ch.last_symbol !== d.last_symbol) begin
                    $error("last_symbol: expected %0b, got %0b", d.last_symbol,
                           out_ch.last_symbol);
                    failed = 1'b1;
                end
                if (out_ch.status !== d.status) begin
                    $error("status: expected %0d, got %0d", d.status, out_ch.status);
                    failed = 1'b1;
                end
            end
        end
        if (quiet) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.end_of_file = 1'b0;
        out_ch.ready = 1'b0;
        failed = 1'b0;
        quiet = 1'b0;
        sent_beats = 0;
        stall_left = 0;
        m_phase = cpcd_pkg::PH_TYPE;
        m_hold = 1'b0;
        m_delta = 1'b0;
        m_index = 0;
        m_total = 0;
        m_remain = 0;
        m_lengths = 0;
        m_asize = 0;
        m_acc = 0;
        m_taken = 0;
        m_prev = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_header_errors();
        test_degenerate_codes();
        test_decoding();
        test_random_files();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
